// ===== hdl/btt_pkg.sv =====
`timescale 1ns / 1ps
package btt_pkg;
  localparam int DEF_BUCKETS = 4096;
  localparam int DEF_WAYS = 4;
  localparam int TAG_W = 34;
  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_PROBE = 3'd1;
  localparam logic [2:0] OP_NEWGEN = 3'd2;
  localparam logic [2:0] OP_CLRFILL = 3'd3;
  localparam logic [2:0] OP_CLRTAB = 3'd4;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [1:0] BK_EXACT = 2'd0;
  localparam logic [1:0] BK_LOWER = 2'd1;
  localparam logic [1:0] BK_UPPER = 2'd2;
  localparam logic [1:0] BK_NONE = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [7:0]       depth;
    logic [1:0]       bound;
    logic [15:0]      score;
    logic [15:0]      move;
    logic [7:0]       age;
  } entry_t;
endpackage

// ===== hdl/btt_fill.sv =====
`timescale 1ns / 1ps
// fill permille: floor(count * 1000 / ENTRIES) as one multiply by a scaled reciprocal,
// exact for every count from 0 to ENTRIES; result valid the cycle after start
module btt_fill import btt_pkg::*; #(
  parameter int ENTRIES = DEF_BUCKETS * DEF_WAYS,
  parameter int CNT_W = $clog2(DEF_BUCKETS * DEF_WAYS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CNT_W-1:0] count,
  output logic             done,
  output logic [9:0]       permille
);
  localparam int SH = CNT_W + $clog2(ENTRIES);
  localparam int MW = CNT_W + 11;
  localparam int PW = CNT_W + MW;
  localparam logic [63:0] RECIP =
    ((64'd1000 << SH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES);
  localparam logic [MW-1:0] MUL = MW'(RECIP);
  logic [PW-1:0] prod;

  assign permille = prod[SH+9:SH];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      prod <= '0;
    end else begin
      done <= start;
      if (start) prod <= {{MW{1'b0}}, count} * {{CNT_W{1'b0}}, MUL};
    end
  end
endmodule

// ===== hdl/bucketed_transposition_table_unit.sv =====
`timescale 1ns / 1ps
// channel | valid    | stall     | payload
// in      | in_valid | in_stall  | opcode key depth bound_kind score move alpha beta
// out     | out_valid| out_stall | usable entry_copied out_move out_score out_depth
//         |          |           | out_bound fill_permille
// Write/probe: the ways are read one at a time through the single read port, each
// way an address state (S_READ), then the shared compare (S_SCAN); a write-back
// state (S_WB) and the registered permille multiply (S_FILL) lead to S_OUT. Other
// opcodes but clear-table go to S_FILL at once. in_stall is high until the result
// is taken. Reset and clear-table sweep all BUCKETS*WAYS entries, one entry a cycle,
// with in_stall high. A waiting result holds in its register while out_stall is high.
module bucketed_transposition_table_unit import btt_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int WAYS = DEF_WAYS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          opcode,
  input  logic [TAG_W-1:0]    key,
  input  logic [7:0]          depth,
  input  logic [1:0]          bound_kind,
  input  logic signed [15:0]  score,
  input  logic [15:0]         move,
  input  logic signed [15:0]  alpha,
  input  logic signed [15:0]  beta,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                usable,
  output logic                entry_copied,
  output logic [15:0]         out_move,
  output logic signed [15:0]  out_score,
  output logic [7:0]          out_depth,
  output logic [1:0]          out_bound,
  output logic [9:0]          fill_permille
);
  localparam int ENTRIES = BUCKETS * WAYS;
  localparam int AW = $clog2(ENTRIES);
  localparam int BW = $clog2(BUCKETS);
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_SCAN, S_WB, S_FILL, S_OUT} state_t;
  state_t state;

  entry_t mem [ENTRIES];
  logic   vld [ENTRIES];
  entry_t rd;
  logic   rd_v;
  logic [AW-1:0] raddr, waddr, caddr;
  logic          we;
  entry_t        wdata;
  logic          wv;

  logic [2:0] op;
  logic [TAG_W-1:0] tag;
  logic [7:0] dep;
  logic [1:0] bk;
  logic signed [15:0] sc, al, be;
  logic [15:0] mv;
  logic [WW-1:0] way, sel;
  logic [WW:0]   scanned;
  logic signed [9:0] best;
  logic found;
  entry_t hit;
  logic hit_v;
  logic [7:0] generation;
  logic [CNT_W-1:0] filled;
  logic fstart, fdone;
  logic [9:0] fperm;

  logic [AW-1:0] base_addr;
  logic signed [9:0] rel;
  logic match;

  assign base_addr = AW'(tag[BW-1:0]) * AW'(WAYS);
  assign rel = $signed({2'b0, rd.depth}) - $signed({2'b0, 8'(generation - rd.age)});
  assign match = rd_v && rd.tag == tag;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
      vld[waddr] <= wv;
    end
    rd <= mem[raddr];
    rd_v <= vld[raddr];
  end

  btt_fill #(.ENTRIES(ENTRIES), .CNT_W(CNT_W)) u_fill (
    .clk, .rst, .start(fstart), .count(filled), .done(fdone), .permille(fperm)
  );

  assign in_stall = (state != S_IDLE);

  always_comb begin
    raddr = base_addr + AW'(way);
    we = 1'b0;
    waddr = base_addr + AW'(sel);
    wv = 1'b1;
    wdata = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = caddr;
      wv = 1'b0;
    end else if (state == S_WB && op == OP_WRITE) begin
      wdata.tag = tag;
      wdata.depth = dep;
      wdata.bound = bk;
      wdata.score = sc;
      wdata.age = generation;
      wdata.move = (hit_v && hit.tag == tag && mv == 16'd0) ? hit.move : mv;
      we = !(hit_v && hit.tag == tag
             && {2'b0, hit.depth} > (({2'b0, dep} * 10'd3) >> 1)
             && bk != BK_EXACT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      caddr <= '0;
      generation <= '0;
      filled <= '0;
      out_valid <= 1'b0;
      fstart <= 1'b0;
      op <= OP_WRITE;
    end else begin
      fstart <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          caddr <= caddr + 1'b1;
          if (caddr == AW'(ENTRIES - 1)) begin
            // only a clear-table word is answered; the sweep after reset is not
            if (op == OP_CLRTAB) begin
              state <= S_FILL;
              fstart <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: if (in_valid) begin
          op <= opcode; tag <= key; dep <= depth; bk <= bound_kind;
          sc <= score; mv <= move; al <= alpha; be <= beta;
          way <= '0; sel <= '0; scanned <= '0; best <= 10'sd511; found <= 1'b0;
          usable <= 1'b0; entry_copied <= 1'b0; out_move <= '0; out_score <= '0;
          out_depth <= '0; out_bound <= '0;
          if (opcode == OP_WRITE || opcode == OP_PROBE) state <= S_READ;
          else begin
            if (opcode == OP_NEWGEN) generation <= generation + 1'b1;
            if (opcode == OP_CLRFILL) filled <= '0;
            if (opcode == OP_CLRTAB) begin
              generation <= '0; filled <= '0; caddr <= '0; state <= S_CLEAR;
            end else begin
              fstart <= 1'b1; state <= S_FILL;
            end
          end
        end
        S_READ: state <= S_SCAN;
        S_SCAN: begin
          // one way per visit, first hit wins
          if (!found) begin
            if (op == OP_PROBE ? match : (!rd_v || match)) begin
              found <= 1'b1; sel <= way; hit <= rd; hit_v <= rd_v;
            end else if (op == OP_WRITE && rel < best) begin
              best <= rel; sel <= way; hit <= rd; hit_v <= rd_v;
            end
          end
          if (scanned == (WW+1)'(WAYS - 1) || (op == OP_PROBE ? match : (!rd_v || match))) begin
            state <= S_WB;
          end else begin
            way <= way + 1'b1; scanned <= scanned + 1'b1; state <= S_READ;
          end
        end
        S_WB: begin
          if (op == OP_WRITE) begin
            if (we && !hit_v) filled <= filled + 1'b1;
          end else if (found) begin
            out_move <= hit.move;
            if (hit.depth >= dep) begin
              case (hit.bound)
                BK_EXACT: begin
                  usable <= 1'b1; entry_copied <= 1'b1; out_score <= hit.score;
                  out_depth <= hit.depth; out_bound <= hit.bound;
                end
                BK_LOWER: begin
                  usable <= (al >= $signed(hit.score)); entry_copied <= 1'b1;
                  out_score <= al; out_depth <= hit.depth; out_bound <= hit.bound;
                end
                BK_UPPER: begin
                  usable <= (be <= $signed(hit.score)); entry_copied <= 1'b1;
                  out_score <= be; out_depth <= hit.depth; out_bound <= hit.bound;
                end
                default: ;
              endcase
            end
          end
          fstart <= 1'b1;
          state <= S_FILL;
        end
        S_FILL: if (fdone) begin
          fill_permille <= fperm;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // reset sweep must not present a word: out_valid only in S_OUT
  a_ovalid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("out_valid outside output state");
  a_nofill: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !fstart) else $error("divider busy in idle");
  a_fill_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill_permille <= 10'd1000) else $error("fill permille out of range");
endmodule
